// ----- rtl/qsort_pkg.sv -----
`timescale 1ns / 1ps
package qsort_pkg;

	// width of the value fields on both channels
	localparam int VALUE_W = 32;

	// parameter defaults for the top level
	localparam int MAX_ITEMS_DEF  = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// sequencer states
	typedef enum logic [3:0] {
		S_LOAD,
		S_PART_INIT,
		S_PIVOT,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SCAN_SWAP,
		S_FIN_RD,
		S_FIN_WR1,
		S_FIN_WR2,
		S_NEXT,
		S_POP,
		S_EMIT_RD,
		S_EMIT_LOAD,
		S_EMIT_WAIT
	} seq_state_t;

	// per-result marks that travel beside the sorted element
	typedef struct packed {
		logic end_of_run;
		logic overflow;
	} run_flags_t;

endpackage

// ----- rtl/qsort_if.sv -----
`timescale 1ns / 1ps

// input channel: one element per request
interface qsort_in_if import qsort_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      last;

	modport source (output valid, value, last, input ready);
	modport sink (input valid, value, last, output ready);
endinterface

// result channel: one sorted element per request
interface qsort_out_if import qsort_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] sorted_value;
	logic                      end_of_run;
	logic                      overflow;

	modport source (output valid, sorted_value, end_of_run, overflow, input ready);
	modport sink (input valid, sorted_value, end_of_run, overflow, output ready);
endinterface

// ----- rtl/qsort_elem_ram.sv -----
`timescale 1ns / 1ps
module qsort_elem_ram import qsort_pkg::*; #(
	parameter int DEPTH = MAX_ITEMS_DEF,
	parameter int WIDTH = DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// ----- rtl/qsort_seq.sv -----
`timescale 1ns / 1ps
module qsort_seq import qsort_pkg::*; #(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int IW = $clog2(MAX_ITEMS),
	localparam int CW = $clog2(MAX_ITEMS + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// load side
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] in_key,
	input  logic                         in_last,
	// result side
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] out_key,
	output run_flags_t                   out_flags,
	// element memory port
	output logic                         ram_we,
	output logic [IW-1:0]                ram_waddr,
	output logic [DATA_WIDTH-1:0]        ram_wdata,
	output logic [IW-1:0]                ram_raddr0,
	output logic [IW-1:0]                ram_raddr1,
	input  logic signed [DATA_WIDTH-1:0] ram_rdata0,
	input  logic signed [DATA_WIDTH-1:0] ram_rdata1
);

	seq_state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] sp_q;
	logic          out_valid_q;

	logic [IW-1:0] lo_q, hi_q, i_q, idx_q, k_q;
	logic signed [DATA_WIDTH-1:0] pivot_q, swap_q;

	// range stack memory, entries are {left, right}
	logic [2*IW-1:0] stack_mem [MAX_ITEMS];
	logic [2*IW-1:0] stack_rd_q;
	logic            push;
	logic [IW-1:0]   stack_raddr;

	logic          accept, full, finish;
	logic [CW-1:0] n_next;
	logic          less;
	logic          right_ok, left_ok;
	logic          scan_done;
	logic          run_last;
	logic [IW-1:0] idx_inc, idx_dec;

	// shared compare unit: signed less-than against the pivot
	assign less = ram_rdata0 < pivot_q;

	assign accept   = in_valid && in_ready;
	assign full     = count_q == CW'(MAX_ITEMS);
	assign finish   = in_last || full;
	assign n_next   = full ? count_q : count_q + CW'(1);
	assign idx_inc  = idx_q + IW'(1);
	assign idx_dec  = idx_q - IW'(1);
	assign scan_done = i_q == hi_q;
	assign run_last = (CW'(k_q) + CW'(1)) == count_q;

	// subranges around the final pivot place that still hold two or more
	assign right_ok = ((IW + 1)'(idx_q) + (IW + 1)'(1)) < (IW + 1)'(hi_q);
	assign left_ok  = (IW + 1)'(idx_q) > ((IW + 1)'(lo_q) + (IW + 1)'(1));

	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = count_q[IW-1:0];
		ram_wdata   = in_key;
		ram_raddr0  = i_q;
		ram_raddr1  = idx_inc;
		push        = 1'b0;
		stack_raddr = IW'(sp_q - CW'(1));
		unique case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ram_we = !full;
					if (finish) begin
						state_d = (n_next < CW'(2)) ? S_EMIT_RD : S_PART_INIT;
					end
				end
			end
			S_PART_INIT: begin
				ram_raddr0 = lo_q;
				state_d    = S_PIVOT;
			end
			S_PIVOT: begin
				state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (less) begin
					ram_we    = 1'b1;
					ram_waddr = idx_inc;
					ram_wdata = ram_rdata0;
					state_d   = S_SCAN_SWAP;
				end else begin
					state_d = scan_done ? S_FIN_RD : S_SCAN_RD;
				end
			end
			S_SCAN_SWAP: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_wdata = swap_q;
				state_d   = scan_done ? S_FIN_RD : S_SCAN_RD;
			end
			S_FIN_RD: begin
				ram_raddr0 = idx_q;
				state_d    = S_FIN_WR1;
			end
			S_FIN_WR1: begin
				ram_we    = 1'b1;
				ram_waddr = lo_q;
				ram_wdata = ram_rdata0;
				state_d   = S_FIN_WR2;
			end
			S_FIN_WR2: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = pivot_q;
				state_d   = S_NEXT;
			end
			S_NEXT: begin
				if (right_ok || left_ok) begin
					push    = right_ok && left_ok;
					state_d = S_PART_INIT;
				end else if (sp_q != '0) begin
					state_d = S_POP;
				end else begin
					state_d = S_EMIT_RD;
				end
			end
			S_POP: begin
				state_d = S_PART_INIT;
			end
			S_EMIT_RD: begin
				ram_raddr0 = k_q;
				state_d    = S_EMIT_LOAD;
			end
			S_EMIT_LOAD: begin
				state_d = S_EMIT_WAIT;
			end
			S_EMIT_WAIT: begin
				if (out_ready) begin
					state_d = run_last ? S_LOAD : S_EMIT_RD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_LOAD && accept) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (push) begin
				sp_q <= sp_q + CW'(1);
			end else if (state_q == S_NEXT && !right_ok && !left_ok && sp_q != '0) begin
				sp_q <= sp_q - CW'(1);
			end
			if (state_q == S_EMIT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (state_q == S_EMIT_WAIT && out_ready) begin
				out_valid_q <= 1'b0;
				if (run_last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end
		end
	end

	// range, scan and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				lo_q <= '0;
				hi_q <= IW'(n_next - CW'(1));
				k_q  <= '0;
			end
			S_PIVOT: begin
				pivot_q <= ram_rdata0;
				idx_q   <= lo_q;
				i_q     <= lo_q + IW'(1);
			end
			S_SCAN_CMP: begin
				if (less) begin
					swap_q <= ram_rdata1;
					idx_q  <= idx_inc;
				end else if (!scan_done) begin
					i_q <= i_q + IW'(1);
				end
			end
			S_SCAN_SWAP: begin
				if (!scan_done) begin
					i_q <= i_q + IW'(1);
				end
			end
			S_NEXT: begin
				// keep the left part in hand, the right one goes to the stack
				if (left_ok) begin
					hi_q <= idx_dec;
				end else if (right_ok) begin
					lo_q <= idx_inc;
				end
			end
			S_POP: begin
				lo_q <= stack_rd_q[2*IW-1:IW];
				hi_q <= stack_rd_q[IW-1:0];
			end
			S_EMIT_LOAD: begin
				out_key              <= ram_rdata0;
				out_flags.end_of_run <= run_last;
				out_flags.overflow   <= ovf_q;
			end
			S_EMIT_WAIT: begin
				if (out_ready) begin
					k_q <= k_q + IW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// range stack write and registered read
	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[sp_q[IW-1:0]] <= {idx_inc, hi_q};
		end
		stack_rd_q <= stack_mem[stack_raddr];
	end

	// no load while a result is still held
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid_q)
		else $error("input ready while a result is pending");

	// store fill never passes its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("item count beyond store depth");

	// scan keeps the boundary behind the scan index and inside the range
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_RD) |-> (idx_q < i_q && i_q <= hi_q && lo_q <= idx_q))
		else $error("partition indexes out of order");

	// pending ranges are disjoint and hold two or more elements
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CW'(MAX_ITEMS / 2))
		else $error("range stack deeper than possible");

	// the marked last result closes the run and reopens loading
	a_run_close: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && out_flags.end_of_run)
			|=> (state_q == S_LOAD && count_q == '0 && !ovf_q))
		else $error("run did not close after its last result");

endmodule

// ----- rtl/quicksort_integer_sorter.sv -----
`timescale 1ns / 1ps
// Sorts a set of signed integers in ascending order. Elements arrive one per
// request, one per cycle, until a request marked last; the set is then sorted
// in place by Lomuto-partition quicksort (leftmost element as pivot, pending
// ranges on a small stack) and sent out as a run whose final result carries
// end_of_run. An element arriving when MAX_ITEMS are already held is dropped,
// ends the set and marks every result of that run with overflow. The input is
// not ready from the closing request until the last result is taken. A
// partition of a range reads the leftmost element as pivot, then reads and
// compares each further element in turn, and for an element that moves
// writes both places of the swap; then the pivot is put in its place, the
// subranges are kept or stacked, and a range that comes off the stack takes
// one more step to pop. All compares go through one signed comparator
// against the element memory with two registered read ports and one write
// port. Results leave one at a time: the next element is read only after
// the sink takes the last one. Run time grows quadratically in the worst
// case, on presorted or all-equal data.
module quicksort_integer_sorter import qsort_pkg::*; #(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	qsort_in_if.sink    item,
	qsort_out_if.source result
);

	localparam int IW = $clog2(MAX_ITEMS);

	logic signed [DATA_WIDTH-1:0] in_key;
	logic signed [DATA_WIDTH-1:0] out_key;
	run_flags_t                   out_flags;

	logic                         ram_we;
	logic [IW-1:0]                ram_waddr, ram_raddr0, ram_raddr1;
	logic [DATA_WIDTH-1:0]        ram_wdata, ram_rdata0, ram_rdata1;

	// element as stored: kept low bits, sign-extended to the data width
	assign in_key = DATA_WIDTH'(item.value);

	// result value: low bits of the sign-extended element
	assign result.sorted_value = VALUE_W'(out_key);
	assign result.end_of_run   = out_flags.end_of_run;
	assign result.overflow     = out_flags.overflow;

	qsort_elem_ram #(
		.DEPTH (MAX_ITEMS),
		.WIDTH (DATA_WIDTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr0 (ram_raddr0),
		.raddr1 (ram_raddr1),
		.rdata0 (ram_rdata0),
		.rdata1 (ram_rdata1)
	);

	qsort_seq #(
		.MAX_ITEMS  (MAX_ITEMS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item.valid),
		.in_ready   (item.ready),
		.in_key     (in_key),
		.in_last    (item.last),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_key    (out_key),
		.out_flags  (out_flags),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr0 (ram_raddr0),
		.ram_raddr1 (ram_raddr1),
		.ram_rdata0 (ram_rdata0),
		.ram_rdata1 (ram_rdata1)
	);

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import qsort_pkg::*;

	localparam int MAX_ITEMS     = MAX_ITEMS_DEF;
	localparam int RANDOM_ITEMS  = 30;
	localparam int SETTLE_CYCLES = 50;

	typedef logic signed [VALUE_W-1:0] elem_t;

	localparam elem_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam elem_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// one expected result: element plus its run marks
	typedef struct packed {
		elem_t      value;
		run_flags_t flags;
	} sorted_item_t;

	// content patterns for a data set
	typedef enum {
		FILL_RANDOM,
		FILL_NARROW,
		FILL_EXTREME,
		FILL_ASCENDING,
		FILL_DESCENDING,
		FILL_EQUAL
	} fill_t;

	logic clk;
	logic arst_n;

	qsort_in_if  in_ch ();
	qsort_out_if out_ch ();

	quicksort_integer_sorter #(
		.MAX_ITEMS  (MAX_ITEMS),
		.DATA_WIDTH (DATA_WIDTH_DEF)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch)
	);

	elem_t        held_q[$];
	sorted_item_t sorted_q[$];
	int           mismatch_count = 0;
	int           items_sent = 0;
	bit           source_idle = 1'b1;
	bit           sink_idle = 1'b1;
	int           hold_len = 0;

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	initial begin
		#8000000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t ns mismatch: %s", $time, msg);
	endtask

	// takes one accepted element; when the set closes (last bit or drop), sorts the held set
	function automatic void absorb_element(input elem_t v, input logic l);
		elem_t        run[$];
		elem_t        key;
		sorted_item_t want;
		int           i;
		int           j;
		bit           close;
		bit           dropped;
		close = l;
		dropped = 1'b0;
		// store full: element dropped, set closes with overflow
		if (held_q.size() >= MAX_ITEMS) begin
			dropped = 1'b1;
			close = 1'b1;
		end else begin
			held_q.push_back(v);
		end
		if (close) begin
			run = held_q;
			for (i = 1; i < run.size(); i++) begin
				key = run[i];
				j = i - 1;
				while (j >= 0 && run[j] > key) begin
					run[j+1] = run[j];
					j--;
				end
				run[j+1] = key;
			end
			for (i = 0; i < run.size(); i++) begin
				want.value = run[i];
				want.flags.end_of_run = (i == run.size() - 1);
				want.flags.overflow = dropped;
				sorted_q.push_back(want);
			end
			held_q.delete();
		end
	endfunction

	// watch accepted input requests
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			absorb_element(in_ch.value, in_ch.last);
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		sorted_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (sorted_q.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing expected",
					out_ch.sorted_value));
			end else begin
				want = sorted_q.pop_front();
				if (out_ch.sorted_value !== want.value)
					report_mismatch($sformatf("sorted_value %0d, expected %0d",
						out_ch.sorted_value, want.value));
				if (out_ch.end_of_run !== want.flags.end_of_run)
					report_mismatch($sformatf("end_of_run %b, expected %b",
						out_ch.end_of_run, want.flags.end_of_run));
				if (out_ch.overflow !== want.flags.overflow)
					report_mismatch($sformatf("overflow %b, expected %b",
						out_ch.overflow, want.flags.overflow));
			end
		end
	end

	// result side: random stalls per request, long hold when asked
	initial begin : result_sink
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				stall = hold_len;
				hold_len = 0;
			end else begin
				stall = (sink_idle && $urandom_range(0, 1)) ? $urandom_range(1, 16) : 0;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid && hold_len == 0);
		end
	end

	// offer one element and wait for its request to be taken
	task automatic send_item(input elem_t v, input logic l);
		int gap;
		gap = (source_idle && $urandom_range(0, 1)) ? $urandom_range(1, 16) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= v;
		in_ch.last <= l;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	// one data set of n elements; past MAX_ITEMS the final element is dropped
	task automatic send_set(input int n, input fill_t fill, input logic drop_last);
		elem_t v;
		logic  l;
		int    k;
		v = elem_t'($urandom_range(0, 2000)) - 1000;
		if (fill == FILL_EQUAL)
			v = $urandom;
		for (k = 0; k < n; k++) begin
			case (fill)
				FILL_RANDOM: v = $urandom;
				FILL_NARROW: v = elem_t'($urandom_range(0, 6)) - 3;
				FILL_EXTREME: begin
					case ($urandom_range(0, 4))
						0: v = VALUE_MAX;
						1: v = VALUE_MIN;
						2: v = '0;
						3: v = '1;
						default: v = $urandom;
					endcase
				end
				FILL_ASCENDING: v = v + elem_t'($urandom_range(0, 3));
				FILL_DESCENDING: v = v - elem_t'($urandom_range(0, 3));
				default: ;
			endcase
			if (k != n - 1)
				l = 1'b0;
			else
				l = (n > MAX_ITEMS) ? drop_last : 1'b1;
			send_item(v, l);
		end
	endtask

	// sender goes quiet until every expected result is in
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sorted_q.size() != 0);
	endtask

	// field extremes, single and pair sets, presorted and equal sets
	task automatic test_extremes();
		send_item(VALUE_MAX, 1'b0);
		send_item(VALUE_MIN, 1'b0);
		send_item('0, 1'b0);
		send_item('1, 1'b0);
		send_item(elem_t'(1), 1'b0);
		send_item(VALUE_MIN, 1'b1);
		send_item(VALUE_MIN, 1'b1);
		send_item(VALUE_MAX, 1'b0);
		send_item(VALUE_MAX, 1'b1);
		send_set(5, FILL_ASCENDING, 1'b1);
		send_set(5, FILL_DESCENDING, 1'b1);
		send_set(4, FILL_EQUAL, 1'b1);
	endtask

	// exactly MAX_ITEMS elements, closing request on the last one
	task automatic test_store_full();
		send_set(MAX_ITEMS, FILL_RANDOM, 1'b1);
	endtask

	// one element too many, with and without its last bit
	task automatic test_overflow();
		send_set(MAX_ITEMS + 1, FILL_NARROW, 1'b0);
		send_set(MAX_ITEMS + 1, FILL_RANDOM, 1'b1);
	endtask

	// result side held off while the next set is offered
	task automatic test_backpressure();
		hold_len = 3000;
		send_set(MAX_ITEMS, FILL_RANDOM, 1'b1);
		send_set(8, FILL_NARROW, 1'b1);
	endtask

	// sender waits for each run to come out before the next set
	task automatic test_drain_pause();
		repeat (3) begin
			send_set($urandom_range(2, 20), FILL_RANDOM, 1'b1);
			wait_drained();
		end
	endtask

	// both sides at full rate
	task automatic test_full_rate();
		source_idle = 1'b0;
		sink_idle = 1'b0;
		repeat (4) send_set($urandom_range(1, 40), FILL_RANDOM, 1'b1);
		send_set(MAX_ITEMS + 1, FILL_EXTREME, 1'b1);
		source_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	// random sets: mostly small, some large, a few at or one past the store depth
	task automatic test_random();
		int    start;
		int    n;
		int    pick;
		fill_t fill;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				n = MAX_ITEMS + $urandom_range(0, 1);
			else if (pick <= 3)
				n = $urandom_range(13, 40);
			else
				n = $urandom_range(1, 12);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: fill = FILL_RANDOM;
				4, 5: fill = FILL_NARROW;
				6: fill = FILL_EXTREME;
				7: fill = FILL_ASCENDING;
				8: fill = FILL_DESCENDING;
				default: fill = FILL_EQUAL;
			endcase
			source_idle = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			send_set(n, fill, 1'($urandom_range(0, 1)));
		end
		source_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	// reset, test sequence and final verdict
	initial begin
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.value <= '0;
		in_ch.last <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_store_full();
		test_overflow();
		test_backpressure();
		test_drain_pause();
		test_full_rate();
		test_random();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
